FILE: hw/rtl/detocc_pkg.sv
`timescale 1ns / 1ps

package detocc_pkg;

  localparam int TENTHS_WIDTH  = 16;
  localparam int MINUTES_WIDTH = 10;
  localparam int FLUTTER_W     = 12;
  localparam int EDGE_W        = 8;
  localparam int ELAPSED_W     = 8;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;
  localparam int CFG_ADDR_W  = 5;
  localparam int CFG_DATA_W  = 32;

  // register index, byte address is 4 * index
  typedef enum logic [2:0] {
    REG_DEBOUNCE_TENTHS   = 3'd0,
    REG_HOLD_TENTHS       = 3'd1,
    REG_OCC_GUARD_MINUTES = 3'd2,
    REG_EMPTY_GUARD_MIN   = 3'd3,
    REG_FLUTTER_WINDOW    = 3'd4,
    REG_FLUTTER_EDGES     = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [TENTHS_WIDTH-1:0]  debounce_tenths;
    logic [TENTHS_WIDTH-1:0]  hold_tenths;
    logic [MINUTES_WIDTH-1:0] occupied_guard_minutes;
    logic [MINUTES_WIDTH-1:0] empty_guard_minutes;
    logic [FLUTTER_W-1:0]     flutter_window_seconds;
    logic [EDGE_W-1:0]        flutter_edge_limit;
  } cfg_t;

  typedef struct packed {
    logic                 occupied;
    logic [ELAPSED_W-1:0] elapsed_tenths;
    logic                 minute_pulse;
    logic                 second_pulse;
    logic                 empty_guard_enable;
  } tick_t;

  typedef struct packed {
    logic start_pulse;
    logic end_pulse;
    logic detected;
    logic debounced;
    logic debounce_running;
    logic hold_active;
    logic occupied_fault;
    logic occupied_guard_running;
    logic empty_fault;
    logic empty_guard_running;
    logic flutter_fault;
    logic flutter_window_running;
  } result_t;

endpackage

FILE: hw/rtl/detocc_cfg_regs.sv
`timescale 1ns / 1ps

module detocc_cfg_regs (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [detocc_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [detocc_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [detocc_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                               cfg_pready,
  output detocc_pkg::cfg_t                   cfg
);
  import detocc_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign cfg_pready = 1'b1;
  assign idx        = reg_idx_t'(cfg_paddr[CFG_ADDR_W-1:2]);
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg        = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_DEBOUNCE_TENTHS:   cfg_r.debounce_tenths <= cfg_pwdata[TENTHS_WIDTH-1:0];
        REG_HOLD_TENTHS:       cfg_r.hold_tenths <= cfg_pwdata[TENTHS_WIDTH-1:0];
        REG_OCC_GUARD_MINUTES: cfg_r.occupied_guard_minutes <= cfg_pwdata[MINUTES_WIDTH-1:0];
        REG_EMPTY_GUARD_MIN:   cfg_r.empty_guard_minutes <= cfg_pwdata[MINUTES_WIDTH-1:0];
        REG_FLUTTER_WINDOW:    cfg_r.flutter_window_seconds <= cfg_pwdata[FLUTTER_W-1:0];
        REG_FLUTTER_EDGES:     cfg_r.flutter_edge_limit <= cfg_pwdata[EDGE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_prdata = '0;
    unique case (idx)
      REG_DEBOUNCE_TENTHS:   cfg_prdata = CFG_DATA_W'(cfg_r.debounce_tenths);
      REG_HOLD_TENTHS:       cfg_prdata = CFG_DATA_W'(cfg_r.hold_tenths);
      REG_OCC_GUARD_MINUTES: cfg_prdata = CFG_DATA_W'(cfg_r.occupied_guard_minutes);
      REG_EMPTY_GUARD_MIN:   cfg_prdata = CFG_DATA_W'(cfg_r.empty_guard_minutes);
      REG_FLUTTER_WINDOW:    cfg_prdata = CFG_DATA_W'(cfg_r.flutter_window_seconds);
      REG_FLUTTER_EDGES:     cfg_prdata = CFG_DATA_W'(cfg_r.flutter_edge_limit);
      default:               cfg_prdata = '0;
    endcase
  end

endmodule

FILE: hw/rtl/detocc_core.sv
`timescale 1ns / 1ps

module detocc_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  detocc_pkg::tick_t   tick,
  input  detocc_pkg::cfg_t    cfg,
  output detocc_pkg::result_t result
);
  import detocc_pkg::*;

  logic det_r, deb_r, deb_run_r, hold_r;
  logic of_r, og_r, ef_r, eg_r, fl_r, fl_win_r;
  logic det_nxt, deb_nxt, deb_run_nxt, hold_nxt;
  logic of_nxt, og_nxt, ef_nxt, eg_nxt, fl_nxt, fl_win_nxt;

  logic [TENTHS_WIDTH-1:0]  deb_tmr_r, deb_tmr_nxt, hold_tmr_r, hold_tmr_nxt;
  logic [MINUTES_WIDTH-1:0] og_tmr_r, og_tmr_nxt, eg_tmr_r, eg_tmr_nxt;
  logic [FLUTTER_W-1:0]     fl_tmr_r, fl_tmr_nxt;
  logic [EDGE_W-1:0]        fl_cnt_r, fl_cnt_nxt;

  logic [TENTHS_WIDTH:0]    deb_sum, hold_sum;
  logic [TENTHS_WIDTH-1:0]  deb_sat, hold_sat;
  logic [MINUTES_WIDTH:0]   og_sum, eg_sum;
  logic [MINUTES_WIDTH-1:0] og_sat, eg_sat;
  logic [EDGE_W-1:0]        fl_cnt_inc;
  logic                     fl_en, start, stop;

  // saturating timer adds
  assign deb_sum  = {1'b0, deb_tmr_r} + (TENTHS_WIDTH+1)'(tick.elapsed_tenths);
  assign hold_sum = {1'b0, hold_tmr_r} + (TENTHS_WIDTH+1)'(tick.elapsed_tenths);
  assign deb_sat  = deb_sum[TENTHS_WIDTH] ? '1 : deb_sum[TENTHS_WIDTH-1:0];
  assign hold_sat = hold_sum[TENTHS_WIDTH] ? '1 : hold_sum[TENTHS_WIDTH-1:0];
  assign og_sum   = {1'b0, og_tmr_r} + (MINUTES_WIDTH+1)'(tick.minute_pulse);
  assign eg_sum   = {1'b0, eg_tmr_r} + (MINUTES_WIDTH+1)'(tick.minute_pulse);
  assign og_sat   = og_sum[MINUTES_WIDTH] ? '1 : og_sum[MINUTES_WIDTH-1:0];
  assign eg_sat   = eg_sum[MINUTES_WIDTH] ? '1 : eg_sum[MINUTES_WIDTH-1:0];
  assign fl_cnt_inc = (fl_cnt_r == '1) ? fl_cnt_r : fl_cnt_r + EDGE_W'(1);
  assign fl_en = (cfg.flutter_window_seconds != '0) && (cfg.flutter_edge_limit != '0);

  always_comb begin
    det_nxt      = det_r;
    deb_nxt      = deb_r;
    deb_run_nxt  = deb_run_r;
    hold_nxt     = hold_r;
    of_nxt       = of_r;
    og_nxt       = og_r;
    ef_nxt       = ef_r;
    eg_nxt       = eg_r;
    fl_nxt       = fl_r;
    fl_win_nxt   = fl_win_r;
    deb_tmr_nxt  = deb_tmr_r;
    hold_tmr_nxt = hold_tmr_r;
    og_tmr_nxt   = og_tmr_r;
    eg_tmr_nxt   = eg_tmr_r;
    fl_tmr_nxt   = fl_tmr_r;
    fl_cnt_nxt   = fl_cnt_r;
    start        = 1'b0;
    stop         = 1'b0;

    if (tick.occupied) begin
      if (!det_r) begin
        // leading edge
        start        = 1'b1;
        det_nxt      = 1'b1;
        deb_run_nxt  = 1'b1;
        hold_nxt     = 1'b1;
        eg_nxt       = 1'b1;
        ef_nxt       = 1'b0;
        hold_tmr_nxt = '0;
        eg_tmr_nxt   = '0;
        if (cfg.debounce_tenths == '0) begin
          deb_nxt     = 1'b1;
          deb_run_nxt = 1'b0;
        end
      end else begin
        if (deb_run_r) begin
          deb_tmr_nxt = deb_sat;
          if (deb_sat >= cfg.debounce_tenths) begin
            deb_nxt     = 1'b1;
            deb_run_nxt = 1'b0;
          end
        end
        if (og_tmr_r < cfg.occupied_guard_minutes) begin
          og_tmr_nxt = og_sat;
        end else begin
          og_nxt = 1'b0;
          of_nxt = (cfg.occupied_guard_minutes != '0);
        end
      end
    end else begin
      if (det_r) begin
        // trailing edge
        stop        = 1'b1;
        og_nxt      = 1'b1;
        det_nxt     = 1'b0;
        deb_nxt     = 1'b0;
        deb_run_nxt = 1'b0;
        of_nxt      = 1'b0;
        deb_tmr_nxt = '0;
        og_tmr_nxt  = '0;
        if (cfg.hold_tenths == '0) begin
          hold_nxt = 1'b0;
        end
      end else begin
        if (hold_r) begin
          hold_tmr_nxt = hold_sat;
          if (hold_sat >= cfg.hold_tenths) begin
            hold_nxt = 1'b0;
          end
        end
        if (eg_tmr_r < cfg.empty_guard_minutes) begin
          if (tick.empty_guard_enable) begin
            eg_tmr_nxt = eg_sat;
          end
        end else begin
          eg_nxt = 1'b0;
          ef_nxt = (cfg.empty_guard_minutes != '0);
        end
      end
    end

    // flutter: edge count first, then the second tick on the updated timer
    if (fl_en) begin
      if (start && (fl_cnt_r < cfg.flutter_edge_limit)) begin
        fl_cnt_nxt = fl_cnt_inc;
        if (fl_cnt_inc >= cfg.flutter_edge_limit) begin
          fl_nxt     = 1'b1;
          fl_tmr_nxt = '0;
          fl_cnt_nxt = '0;
        end
      end
      if (tick.second_pulse) begin
        fl_win_nxt = 1'b1;
        if (fl_tmr_nxt < cfg.flutter_window_seconds) begin
          fl_tmr_nxt = (fl_tmr_nxt == '1) ? fl_tmr_nxt : fl_tmr_nxt + FLUTTER_W'(1);
        end else begin
          fl_nxt     = 1'b0;
          fl_tmr_nxt = '0;
          fl_cnt_nxt = '0;
        end
      end
    end else begin
      fl_nxt     = 1'b0;
      fl_win_nxt = 1'b0;
      fl_tmr_nxt = '0;
      fl_cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      det_r      <= 1'b0;
      deb_r      <= 1'b0;
      deb_run_r  <= 1'b0;
      hold_r     <= 1'b0;
      of_r       <= 1'b0;
      og_r       <= 1'b0;
      ef_r       <= 1'b0;
      eg_r       <= 1'b0;
      fl_r       <= 1'b0;
      fl_win_r   <= 1'b0;
      deb_tmr_r  <= '0;
      hold_tmr_r <= '0;
      og_tmr_r   <= '0;
      eg_tmr_r   <= '0;
      fl_tmr_r   <= '0;
      fl_cnt_r   <= '0;
    end else if (step) begin
      det_r      <= det_nxt;
      deb_r      <= deb_nxt;
      deb_run_r  <= deb_run_nxt;
      hold_r     <= hold_nxt;
      of_r       <= of_nxt;
      og_r       <= og_nxt;
      ef_r       <= ef_nxt;
      eg_r       <= eg_nxt;
      fl_r       <= fl_nxt;
      fl_win_r   <= fl_win_nxt;
      deb_tmr_r  <= deb_tmr_nxt;
      hold_tmr_r <= hold_tmr_nxt;
      og_tmr_r   <= og_tmr_nxt;
      eg_tmr_r   <= eg_tmr_nxt;
      fl_tmr_r   <= fl_tmr_nxt;
      fl_cnt_r   <= fl_cnt_nxt;
    end
  end

  assign result.start_pulse            = start;
  assign result.end_pulse              = stop;
  assign result.detected               = det_nxt;
  assign result.debounced              = deb_nxt;
  assign result.debounce_running       = deb_run_nxt;
  assign result.hold_active            = hold_nxt;
  assign result.occupied_fault         = of_nxt;
  assign result.occupied_guard_running = og_nxt;
  assign result.empty_fault            = ef_nxt;
  assign result.empty_guard_running    = eg_nxt;
  assign result.flutter_fault          = fl_nxt;
  assign result.flutter_window_running = fl_win_nxt;

  // hold is set at every leading edge and only cleared while empty
  a_hold_covers_detect: assert property (@(posedge clk) disable iff (!rst_n)
    det_r |-> hold_r) else $error("hold flag low while detected");

  a_debounce_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(deb_r && deb_run_r)) else $error("debounced and debounce timer both set");

  a_debounce_needs_detect: assert property (@(posedge clk) disable iff (!rst_n)
    (deb_r || deb_run_r || of_r) |-> det_r)
    else $error("occupied-side flag set without detection");

  a_empty_fault_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    ef_r |-> !det_r) else $error("empty fault while detected");

  a_flutter_off: assert property (@(posedge clk) disable iff (!rst_n)
    (step && !fl_en) |=> (!fl_r && !fl_win_r && fl_cnt_r == '0))
    else $error("flutter state not cleared while disabled");

endmodule

FILE: hw/rtl/detector_occupancy_conditioner.sv
`timescale 1ns / 1ps

// detector occupancy conditioner, one loop detector per instance
//
// in_*  : one tick item per transfer, raw occupied bit, elapsed tenths,
//         minute/second pulses and empty guard enable
// out_* : one result item per tick, edge pulses and all condition flags
//         as they stand after that tick
// cfg_* : apb-style register port, six registers at byte address 4*i, to be
//         written by the user only while no item is in flight (unenforced)
//
// an accepted item lands in an input register; the state update then runs
// in one pass and its result is registered in the result register, which
// offers it; an output stall can hold the item in the input register first.
// throughput is one item per cycle while out_tready stays high, set by the
// one-pass state update loop in the core
// a stalled out_tready holds the result register; the input register still
// drains into it once it empties, and in_tready drops only when both are full
// reset clears config regs, timers, flags and both valid bits, not payloads

module detector_occupancy_conditioner (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [0] occupied, [8:1] elapsed_tenths, [9] minute_pulse, [10] second_pulse,
  // [11] empty_guard_enable, [15:12] zero
  input  logic [detocc_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [0] start_pulse, [1] end_pulse, [2] detected, [3] debounced,
  // [4] debounce_running, [5] hold_active, [6] occupied_fault,
  // [7] occupied_guard_running, [8] empty_fault, [9] empty_guard_running,
  // [10] flutter_fault, [11] flutter_window_running, [15:12] zero
  output logic [detocc_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [detocc_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [detocc_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [detocc_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                                cfg_pready
);
  import detocc_pkg::*;

  cfg_t    cfg;
  tick_t   tick_r;
  logic    tick_valid_r;
  result_t result;
  result_t res_r;
  logic    out_valid_r;
  logic    advance;
  logic    in_accept;

  detocc_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // the input register moves on when the result register is free
  assign advance   = tick_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !tick_valid_r || advance;
  assign in_accept = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_valid_r <= 1'b0;
    end else if (in_tready) begin
      tick_valid_r <= in_tvalid;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_accept) begin
      tick_r.occupied           <= in_tdata[0];
      tick_r.elapsed_tenths     <= in_tdata[8:1];
      tick_r.minute_pulse       <= in_tdata[9];
      tick_r.second_pulse       <= in_tdata[10];
      tick_r.empty_guard_enable <= in_tdata[11];
    end
  end

  detocc_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .tick   (tick_r),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000,
                       res_r.flutter_window_running,
                       res_r.flutter_fault,
                       res_r.empty_guard_running,
                       res_r.empty_fault,
                       res_r.occupied_guard_running,
                       res_r.occupied_fault,
                       res_r.hold_active,
                       res_r.debounce_running,
                       res_r.debounced,
                       res_r.detected,
                       res_r.end_pulse,
                       res_r.start_pulse};

endmodule
